// ----- src/lvwf_pkg.sv -----
// Shared constants and codes for the least-visited wall follower.
`default_nettype none
package lvwf_pkg;

    localparam int MAX_WIDTH_DEF  = 16;
    localparam int MAX_HEIGHT_DEF = 16;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] VISIT_LIMIT = 16'hFFFF;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAZE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAZE_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  MAZE_WIDTH_RST  = 5'd16;
    localparam logic [CFG_DATA_W-1:0]  MAZE_HEIGHT_RST = 5'd16;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [1:0] TURN_RIGHT = 2'd1;
    localparam logic [1:0] TURN_FRONT = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd3;
    localparam logic [1:0] TURN_BACK  = 2'd2;

endpackage
`default_nettype wire

// ----- src/lvwf_count_ram.sv -----
// Visit count memory: one write port, one registered read port.
`default_nettype none
module lvwf_count_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [AW-1:0]                i_wr_addr,
    input  wire  [lvwf_pkg::COUNT_W-1:0] i_wr_data,
    input  wire  [AW-1:0]                i_rd_addr,
    output logic [lvwf_pkg::COUNT_W-1:0] o_rd_data
);

    logic [lvwf_pkg::COUNT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ----- src/least_visited_wall_follower_top.sv -----
// Top level of the least-visited wall follower: sequencer, neighbour scan, ports.
//
// channel  dir  handshake                  payload
// s        in   i_s_tvalid / o_s_tready    i_s_tdata: cell_x, cell_y, heading, wall_mask
// m        out  o_m_tvalid / i_m_tready    o_m_tdata: move_found, move_direction
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item passes through accept, five count reads on the single memory read port
// (current cell, then right, front, left, back), one final compare, one result load.
// A cell outside the maze skips the reads and goes from accept to the result load.
// After reset a clearing pass writes MAX_WIDTH*MAX_HEIGHT zero counts, one per cycle;
// o_s_tready stays low meanwhile. Config beats are taken at any time.
// A beat may be accepted while the previous result waits; the next result is held
// in the sequencer until the output register is free.
`default_nettype none
module least_visited_wall_follower_top #(
    parameter int MAX_WIDTH  = lvwf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lvwf_pkg::MAX_HEIGHT_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // [3:0] cell_x, [7:4] cell_y, [9:8] heading, [13:10] wall_mask, [15:14] zero
    input  wire  [15:0]                     i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // [0] move_found, [2:1] move_direction, [7:3] zero
    output logic [7:0]                      o_m_tdata,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [lvwf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [lvwf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = lvwf_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LAST,
        S_DONE
    } t_state;

    t_state  r_state;
    logic [2:0] r_k;
    logic       r_pend;
    logic [2:0] r_pend_k;
    logic       r_pend_open;
    logic [1:0] r_pend_dir;
    logic [3:0] r_x;
    logic [3:0] r_y;
    logic [1:0] r_h;
    logic [3:0] r_walls;
    logic       r_found;
    logic [1:0] r_best_dir;
    logic [CW-1:0] r_best_v;
    logic [AW-1:0] r_cur_idx;
    logic [AW-1:0] r_clr_addr;
    logic       r_out_valid;
    logic       r_out_found;
    logic [1:0] r_out_dir;
    logic [lvwf_pkg::CFG_DATA_W-1:0] r_maze_width;
    logic [lvwf_pkg::CFG_DATA_W-1:0] r_maze_height;

    logic [3:0] w_in_x;
    logic [3:0] w_in_y;
    logic       w_in_inside;
    logic       w_s_beat;
    logic       w_out_free;

    logic [1:0]    w_dir;
    logic          w_open;
    logic [4:0]    w_nx;
    logic [4:0]    w_ny;
    logic [AW-1:0] w_rd_addr;
    logic [CW-1:0] w_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [CW-1:0] w_wr_data;
    logic          w_take;

    assign w_in_x   = i_s_tdata[3:0];
    assign w_in_y   = i_s_tdata[7:4];
    assign w_s_beat = i_s_tvalid && o_s_tready;
    assign w_in_inside = ({1'b0, w_in_x} < r_maze_width) && (int'(w_in_x) < MAX_WIDTH) &&
                         ({1'b0, w_in_y} < r_maze_height) && (int'(w_in_y) < MAX_HEIGHT);
    assign w_out_free  = !r_out_valid || i_m_tready;

    // Neighbour for scan slot r_k (1 right, 2 front, 3 left, 4 back)
    always_comb begin
        case (r_k)
            3'd1:    w_dir = r_h + lvwf_pkg::TURN_RIGHT;
            3'd2:    w_dir = r_h + lvwf_pkg::TURN_FRONT;
            3'd3:    w_dir = r_h + lvwf_pkg::TURN_LEFT;
            default: w_dir = r_h + lvwf_pkg::TURN_BACK;
        endcase
        w_nx = {1'b0, r_x};
        w_ny = {1'b0, r_y};
        case (w_dir)
            lvwf_pkg::DIR_UP: begin
                w_open = ({1'b0, r_y} + 5'd1 < r_maze_height) && (int'(r_y) + 1 < MAX_HEIGHT);
                w_ny   = {1'b0, r_y} + 5'd1;
            end
            lvwf_pkg::DIR_RIGHT: begin
                w_open = ({1'b0, r_x} + 5'd1 < r_maze_width) && (int'(r_x) + 1 < MAX_WIDTH);
                w_nx   = {1'b0, r_x} + 5'd1;
            end
            lvwf_pkg::DIR_DOWN: begin
                w_open = (r_y != 4'd0);
                w_ny   = {1'b0, r_y} - 5'd1;
            end
            default: begin
                w_open = (r_x != 4'd0);
                w_nx   = {1'b0, r_x} - 5'd1;
            end
        endcase
        w_open = w_open && !r_walls[w_dir];
        if (r_k == 3'd0 || !w_open) begin
            w_rd_addr = r_cur_idx;
        end else begin
            w_rd_addr = AW'(int'(w_ny) * MAX_WIDTH + int'(w_nx));
        end
    end

    // Shared compare / increment on the registered read count; zero writes while clearing
    always_comb begin
        w_take    = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur_idx;
        w_wr_data = (w_rd_data == lvwf_pkg::VISIT_LIMIT) ? w_rd_data : w_rd_data + CW'(1);
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else if (r_pend) begin
            if (r_pend_k == 3'd0) begin
                w_wr_en = 1'b1;
            end else begin
                w_take = r_pend_open && (!r_found || (w_rd_data < r_best_v));
            end
        end
    end

    lvwf_count_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_k           <= 3'd0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_maze_width  <= lvwf_pkg::MAZE_WIDTH_RST;
            r_maze_height <= lvwf_pkg::MAZE_HEIGHT_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lvwf_pkg::REG_MAZE_WIDTH:  r_maze_width  <= i_cfg_data;
                    lvwf_pkg::REG_MAZE_HEIGHT: r_maze_height <= i_cfg_data;
                    default: ;
                endcase
            end

            r_pend      <= (r_state == S_READ);
            r_pend_k    <= r_k;
            r_pend_open <= w_open;
            r_pend_dir  <= w_dir;

            if (w_take) begin
                r_found    <= 1'b1;
                r_best_v   <= w_rd_data;
                r_best_dir <= r_pend_dir;
            end

            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(CELL_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_x       <= w_in_x;
                        r_y       <= w_in_y;
                        r_h       <= i_s_tdata[9:8];
                        r_walls   <= i_s_tdata[13:10];
                        r_cur_idx <= AW'(int'(w_in_y) * MAX_WIDTH + int'(w_in_x));
                        r_found   <= 1'b0;
                        r_k       <= 3'd0;
                        r_state   <= w_in_inside ? S_READ : S_DONE;
                    end
                end
                S_READ: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_dir   <= r_found ? r_best_dir : lvwf_pkg::DIR_UP;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {5'd0, r_out_dir, r_out_found};

    a_beat_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_beat |=> (r_state == S_READ && r_k == 3'd0) || r_state == S_DONE)
        else $error("accepted beat did not start a scan");

    a_count_not_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_pend_k == 3'd0) |-> (w_wr_en && w_wr_data >= w_rd_data))
        else $error("visit count update lost or decreased");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the load step");

    a_no_move_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[2:1] == lvwf_pkg::DIR_UP))
        else $error("direction set without a move");

endmodule
`default_nettype wire
